[rtl/lcabl_pkg.sv]
// shared types, constants and helpers for the binary-lifting lca engine
package lcabl_pkg;

   localparam int NODE_W   = 10;
   localparam int DEPTH_W  = 11;
   localparam int WEIGHT_W = 32;
   // level field in the command word, wide enough for the largest level count
   localparam int LVL_W    = 4;

   localparam int LCABL_MAX_NODES  = 1024;
   localparam int LCABL_LOG_LEVELS = 10;

   localparam logic signed [WEIGHT_W-1:0] INF = 32'sh7FFF_FFFF;

   typedef struct packed {
      logic                       mode;
      logic [NODE_W-1:0]          node_a;
      logic [NODE_W-1:0]          node_b;
      logic signed [WEIGHT_W-1:0] weight;
   } req_type;

   typedef struct packed {
      logic [NODE_W-1:0]          ancestor;
      logic signed [WEIGHT_W-1:0] path_min;
   } rsp_type;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_CAPTURE,
      OP_LD_RD,
      OP_LD_UPD,
      OP_LD_LAST,
      OP_Q_BAD,
      OP_Q_DEP,
      OP_Q_SWAP,
      OP_Q_LA,
      OP_Q_LD,
      OP_Q_LC,
      OP_Q_SAME,
      OP_Q_PA,
      OP_Q_PC,
      OP_Q_FC
   } dp_op_type;

   typedef struct packed {
      dp_op_type        op;
      logic [LVL_W-1:0] lvl;
   } cmd_type;

   typedef struct packed {
      logic is_query;
      logic load_ok;
      logic query_ok;
      logic a_eq_b;
   } stat_type;

   function automatic logic signed [WEIGHT_W-1:0] min_w(
      input logic signed [WEIGHT_W-1:0] x,
      input logic signed [WEIGHT_W-1:0] y
   );
      return (x < y) ? x : y;
   endfunction

endpackage

[rtl/lcabl_ram.sv]
// generic ram, one write port and two registered read ports
module lcabl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr0,
   input  logic [$clog2(DEPTH)-1:0] raddr1,
   output logic [WIDTH-1:0]         rdata0,
   output logic [WIDTH-1:0]         rdata1
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata0 <= mem[raddr0];
         rdata1 <= mem[raddr1];
      end
   end

endmodule

[rtl/lcabl_ctrl.sv]
// sequencer for load and query walks of the lifting tables
module lcabl_ctrl import lcabl_pkg::*; #(
   parameter int LOG_LEVELS = LCABL_LOG_LEVELS
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   output logic     busy,
   input  stat_type stat,
   output cmd_type  cmd,
   output logic     rsp_strobe
);

   localparam int LW = $clog2(LOG_LEVELS);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_L_READ,
      ST_L_UPD,
      ST_L_LAST,
      ST_Q_SWAP,
      ST_Q_LA,
      ST_Q_LD,
      ST_Q_LC,
      ST_Q_EQ,
      ST_Q_PA,
      ST_Q_PC,
      ST_Q_FA,
      ST_Q_FC
   } state_type;

   state_type      state_ff, state_in;
   logic [LW-1:0]  lvl_ff, lvl_in;
   logic           busy_ff, busy_in;
   logic           rsp_strobe_ff, rsp_strobe_in;
   dp_op_type      op;

   always_comb begin
      state_in      = state_ff;
      lvl_in        = lvl_ff;
      rsp_strobe_in = 1'b0;
      op            = OP_NOP;
      unique case (state_ff)
         ST_IDLE: begin
            if (start && !busy_ff) begin
               op       = OP_CAPTURE;
               lvl_in   = '0;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (!stat.is_query) begin
               if (stat.load_ok) begin
                  op       = OP_LD_RD;
                  state_in = ST_L_UPD;
               end else begin
                  state_in = ST_IDLE;
               end
            end else if (stat.query_ok) begin
               op       = OP_Q_DEP;
               state_in = ST_Q_SWAP;
            end else begin
               op            = OP_Q_BAD;
               rsp_strobe_in = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_L_READ: begin
            op       = OP_LD_RD;
            state_in = ST_L_UPD;
         end
         ST_L_UPD: begin
            op     = OP_LD_UPD;
            lvl_in = lvl_ff + LW'(1);
            if (lvl_ff == LW'(LOG_LEVELS - 2)) begin
               state_in = ST_L_LAST;
            end else begin
               state_in = ST_L_READ;
            end
         end
         ST_L_LAST: begin
            op       = OP_LD_LAST;
            state_in = ST_IDLE;
         end
         ST_Q_SWAP: begin
            op       = OP_Q_SWAP;
            lvl_in   = LW'(LOG_LEVELS - 1);
            state_in = ST_Q_LA;
         end
         ST_Q_LA: begin
            op       = OP_Q_LA;
            state_in = ST_Q_LD;
         end
         ST_Q_LD: begin
            op       = OP_Q_LD;
            state_in = ST_Q_LC;
         end
         ST_Q_LC: begin
            op = OP_Q_LC;
            if (lvl_ff == '0) begin
               lvl_in   = LW'(LOG_LEVELS - 1);
               state_in = ST_Q_EQ;
            end else begin
               lvl_in   = lvl_ff - LW'(1);
               state_in = ST_Q_LA;
            end
         end
         ST_Q_EQ: begin
            if (stat.a_eq_b) begin
               op            = OP_Q_SAME;
               rsp_strobe_in = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               op       = OP_Q_PA;
               state_in = ST_Q_PC;
            end
         end
         ST_Q_PA: begin
            op       = OP_Q_PA;
            state_in = ST_Q_PC;
         end
         ST_Q_PC: begin
            op = OP_Q_PC;
            if (lvl_ff == '0) begin
               state_in = ST_Q_FA;
            end else begin
               lvl_in   = lvl_ff - LW'(1);
               state_in = ST_Q_PA;
            end
         end
         ST_Q_FA: begin
            op       = OP_Q_PA;
            state_in = ST_Q_FC;
         end
         ST_Q_FC: begin
            op            = OP_Q_FC;
            rsp_strobe_in = 1'b1;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      busy_in = (state_in != ST_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         lvl_ff        <= '0;
         busy_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         lvl_ff        <= lvl_in;
         busy_ff       <= busy_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   assign cmd.op     = op;
   assign cmd.lvl    = LVL_W'(lvl_ff);
   assign busy       = busy_ff;
   assign rsp_strobe = rsp_strobe_ff;

`ifndef SYNTHESIS
   a_strobe_in_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> state_ff == ST_IDLE)
      else $error("result strobe outside idle");
   a_strobe_query: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> stat.is_query)
      else $error("result strobe for a load word");
   a_dispatch_after_accept: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DISPATCH |-> $past(start) && $past(state_ff) == ST_IDLE)
      else $error("dispatch without an accepted word");
   a_load_only_valid: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_L_UPD |-> stat.load_ok && !stat.is_query)
      else $error("table write for a rejected load");
   a_busy_tracks_state: assert property (@(posedge clock) disable iff (reset)
      busy_ff == (state_ff != ST_IDLE))
      else $error("busy out of step with state");
`endif

endmodule

[rtl/lcabl_dp.sv]
// datapath: lifting tables, depth table, walk registers and result register
module lcabl_dp import lcabl_pkg::*; #(
   parameter int MAX_NODES  = LCABL_MAX_NODES,
   parameter int LOG_LEVELS = LCABL_LOG_LEVELS
) (
   input  logic     clock,
   input  req_type  req_word,
   input  cmd_type  cmd,
   output stat_type stat,
   output rsp_type  rsp_word
);

   localparam int AW     = $clog2(MAX_NODES);
   localparam int LW     = $clog2(LOG_LEVELS);
   localparam int TAW    = AW + LW;
   localparam int TDEPTH = MAX_NODES * (2 ** LW);

   logic                       mode_ff, mode_in;
   logic [NODE_W-1:0]          a_ff, a_in;
   logic [NODE_W-1:0]          b_ff, b_in;
   logic [NODE_W-1:0]          cur_anc_ff, cur_anc_in;
   logic signed [WEIGHT_W-1:0] acc_ff, acc_in;
   logic signed [WEIGHT_W-1:0] upmin_ff, upmin_in;
   logic [DEPTH_W-1:0]         dep_ref_ff, dep_ref_in;
   rsp_type                    rsp_ff, rsp_in;
   logic                       tz0_ff, tz0_in, tz1_ff, tz1_in;
   logic                       dz0_ff, dz0_in, dz1_ff, dz1_in;

   logic [LW-1:0]              lvl;
   logic                       tab_re, tab_we, dep_re, dep_we;
   logic [NODE_W-1:0]          tnode0, tnode1, dnode0, dnode1;
   logic [TAW-1:0]             tab_ra0, tab_ra1, tab_wa;
   logic [AW-1:0]              dep_ra0, dep_ra1, dep_wa;
   logic [NODE_W-1:0]          anc_rd0, anc_rd1;
   logic [WEIGHT_W-1:0]        min_rd0, min_rd1;
   logic [DEPTH_W-1:0]         dep_rd0, dep_rd1, dep_wd;
   logic [NODE_W-1:0]          anc0, anc1;
   logic signed [WEIGHT_W-1:0] min0, min1, min01;
   logic [DEPTH_W-1:0]         dep0, dep1;

   assign lvl = cmd.lvl[LW-1:0];

   // node 0 is never written; its rows read as zero
   assign anc0  = tz0_ff ? '0 : anc_rd0;
   assign anc1  = tz1_ff ? '0 : anc_rd1;
   assign min0  = tz0_ff ? '0 : $signed(min_rd0);
   assign min1  = tz1_ff ? '0 : $signed(min_rd1);
   assign dep0  = dz0_ff ? '0 : dep_rd0;
   assign dep1  = dz1_ff ? '0 : dep_rd1;
   assign min01 = min_w(min0, min1);

   assign stat.is_query = mode_ff;
   assign stat.load_ok  = (a_ff != '0) && (32'(a_ff) < 32'(MAX_NODES))
                          && (32'(b_ff) < 32'(MAX_NODES));
   assign stat.query_ok = (a_ff != '0) && (b_ff != '0)
                          && (32'(a_ff) < 32'(MAX_NODES))
                          && (32'(b_ff) < 32'(MAX_NODES));
   assign stat.a_eq_b   = (a_ff == b_ff);

   always_comb begin
      mode_in    = mode_ff;
      a_in       = a_ff;
      b_in       = b_ff;
      cur_anc_in = cur_anc_ff;
      acc_in     = acc_ff;
      upmin_in   = upmin_ff;
      dep_ref_in = dep_ref_ff;
      rsp_in     = rsp_ff;
      tab_re     = 1'b0;
      tab_we     = 1'b0;
      dep_re     = 1'b0;
      dep_we     = 1'b0;
      tnode0     = a_ff;
      tnode1     = b_ff;
      dnode0     = a_ff;
      dnode1     = b_ff;
      unique case (cmd.op)
         OP_NOP: begin
         end
         OP_CAPTURE: begin
            mode_in    = req_word.mode;
            a_in       = req_word.node_a;
            b_in       = req_word.node_b;
            cur_anc_in = req_word.node_b;
            acc_in     = req_word.mode ? INF : req_word.weight;
         end
         OP_LD_RD: begin
            tab_re = 1'b1;
            tnode0 = cur_anc_ff;
            dep_re = 1'b1;
            dnode0 = b_ff;
         end
         OP_LD_UPD: begin
            tab_we     = 1'b1;
            cur_anc_in = anc0;
            acc_in     = min_w(acc_ff, min0);
         end
         OP_LD_LAST: begin
            tab_we = 1'b1;
            dep_we = 1'b1;
         end
         OP_Q_BAD: begin
            rsp_in.ancestor = '0;
            rsp_in.path_min = INF;
         end
         OP_Q_DEP: begin
            dep_re = 1'b1;
         end
         OP_Q_SWAP: begin
            if (dep0 > dep1) begin
               a_in       = b_ff;
               b_in       = a_ff;
               dep_ref_in = dep1;
            end else begin
               dep_ref_in = dep0;
            end
         end
         OP_Q_LA: begin
            tab_re = 1'b1;
            tnode0 = b_ff;
         end
         OP_Q_LD: begin
            cur_anc_in = anc0;
            upmin_in   = min0;
            dep_re     = 1'b1;
            dnode0     = anc0;
         end
         OP_Q_LC: begin
            if (dep0 >= dep_ref_ff) begin
               acc_in = min_w(acc_ff, upmin_ff);
               b_in   = cur_anc_ff;
            end
         end
         OP_Q_SAME: begin
            rsp_in.ancestor = a_ff;
            rsp_in.path_min = acc_ff;
         end
         OP_Q_PA: begin
            tab_re = 1'b1;
         end
         OP_Q_PC: begin
            if (anc0 != anc1) begin
               acc_in = min_w(acc_ff, min01);
               a_in   = anc0;
               b_in   = anc1;
            end
         end
         OP_Q_FC: begin
            rsp_in.ancestor = anc0;
            rsp_in.path_min = (anc0 == '0) ? INF : min_w(acc_ff, min01);
         end
         default: begin
         end
      endcase
      tz0_in = tab_re ? (tnode0 == '0) : tz0_ff;
      tz1_in = tab_re ? (tnode1 == '0) : tz1_ff;
      dz0_in = dep_re ? (dnode0 == '0) : dz0_ff;
      dz1_in = dep_re ? (dnode1 == '0) : dz1_ff;
   end

   assign tab_ra0 = {AW'(tnode0), lvl};
   assign tab_ra1 = {AW'(tnode1), lvl};
   assign tab_wa  = {AW'(a_ff), lvl};
   assign dep_ra0 = AW'(dnode0);
   assign dep_ra1 = AW'(dnode1);
   assign dep_wa  = AW'(a_ff);
   assign dep_wd  = dep0 + DEPTH_W'(1);

   always_ff @(posedge clock) begin
      mode_ff    <= mode_in;
      a_ff       <= a_in;
      b_ff       <= b_in;
      cur_anc_ff <= cur_anc_in;
      acc_ff     <= acc_in;
      upmin_ff   <= upmin_in;
      dep_ref_ff <= dep_ref_in;
      rsp_ff     <= rsp_in;
      tz0_ff     <= tz0_in;
      tz1_ff     <= tz1_in;
      dz0_ff     <= dz0_in;
      dz1_ff     <= dz1_in;
   end

   lcabl_ram #(.WIDTH(NODE_W), .DEPTH(TDEPTH)) u_anc_ram (
      .clock  (clock),
      .we     (tab_we),
      .waddr  (tab_wa),
      .wdata  (cur_anc_ff),
      .re     (tab_re),
      .raddr0 (tab_ra0),
      .raddr1 (tab_ra1),
      .rdata0 (anc_rd0),
      .rdata1 (anc_rd1)
   );

   lcabl_ram #(.WIDTH(WEIGHT_W), .DEPTH(TDEPTH)) u_min_ram (
      .clock  (clock),
      .we     (tab_we),
      .waddr  (tab_wa),
      .wdata  (acc_ff),
      .re     (tab_re),
      .raddr0 (tab_ra0),
      .raddr1 (tab_ra1),
      .rdata0 (min_rd0),
      .rdata1 (min_rd1)
   );

   lcabl_ram #(.WIDTH(DEPTH_W), .DEPTH(MAX_NODES)) u_dep_ram (
      .clock  (clock),
      .we     (dep_we),
      .waddr  (dep_wa),
      .wdata  (dep_wd),
      .re     (dep_re),
      .raddr0 (dep_ra0),
      .raddr1 (dep_ra1),
      .rdata0 (dep_rd0),
      .rdata1 (dep_rd1)
   );

   assign rsp_word = rsp_ff;

endmodule

[rtl/lca_binary_lifting_path_min.sv]
// top level of the binary-lifting lca engine with path minimum
//
// usage: a word is taken on req_word at a rising edge with start high and
// busy low. mode 0 loads node_a with parent node_b (0 for a root) and edge
// weight; parents must be loaded before their children. mode 1 queries the
// lowest common ancestor of node_a and node_b and the minimum edge weight on
// the path between them.
// a load gives no result and keeps busy high while it walks the levels (an
// ignored load only passes through dispatch): one dependent ancestor-table
// read per level but the last, and one row write per level, through the
// single table write port. a query gives one result word on rsp_word, marked
// by rsp_strobe for one cycle; each lift level takes a table read, a depth
// read and a compare, each joint level a table read and a compare (the joint
// phase is skipped when the two nodes meet after lifting). busy drops in the
// cycle the result is shown, so the next word may be taken at the same edge
// that takes the result.
// reset clears the sequencer only; tables are not cleared, node 0 reads as
// zero by masking. the receiver cannot stall: the result is shown once.
module lca_binary_lifting_path_min import lcabl_pkg::*; #(
   parameter int MAX_NODES  = LCABL_MAX_NODES,
   parameter int LOG_LEVELS = LCABL_LOG_LEVELS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_word,
   output logic    rsp_strobe,
   output rsp_type rsp_word
);

   // command and status between sequencer and datapath
   cmd_type  cmd;
   stat_type stat;

   // sequencer: walks levels, decides each step from datapath status
   lcabl_ctrl #(.LOG_LEVELS(LOG_LEVELS)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .stat       (stat),
      .cmd        (cmd),
      .rsp_strobe (rsp_strobe)
   );

   // datapath: tables in ram, walk registers, result word register
   lcabl_dp #(.MAX_NODES(MAX_NODES), .LOG_LEVELS(LOG_LEVELS)) u_dp (
      .clock    (clock),
      .req_word (req_word),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_word (rsp_word)
   );

endmodule

[tb/lcabl_test_pkg.sv]
// command codes shared by the lca engine testbench and its checker
`timescale 1ns / 1ps

package lcabl_test_pkg;

   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

endpackage

[tb/lca_path_checker.sv]
// checker: shadow lifting tables, expected lca words, field compare
`timescale 1ns / 1ps

module lca_path_checker import lcabl_pkg::*; import lcabl_test_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_word,
   input  logic    rsp_strobe,
   input  rsp_type rsp_word,
   output int      error_count,
   output int      pending_count
);

   logic [NODE_W-1:0]          lift_up    [LCABL_MAX_NODES][LCABL_LOG_LEVELS];
   logic signed [WEIGHT_W-1:0] lift_min   [LCABL_MAX_NODES][LCABL_LOG_LEVELS];
   logic [DEPTH_W-1:0]         node_depth [LCABL_MAX_NODES];

   rsp_type expected_paths [$];
   int      mismatches;
   int      waiting;

   assign error_count   = mismatches;
   assign pending_count = waiting;

   function automatic logic signed [WEIGHT_W-1:0] lower_of(
      input logic signed [WEIGHT_W-1:0] x,
      input logic signed [WEIGHT_W-1:0] y
   );
      return (x < y) ? x : y;
   endfunction

   task automatic store_node(
      input logic [NODE_W-1:0]          node,
      input logic [NODE_W-1:0]          parent,
      input logic signed [WEIGHT_W-1:0] w
   );
      logic [NODE_W-1:0]          up [LCABL_LOG_LEVELS];
      logic signed [WEIGHT_W-1:0] lo [LCABL_LOG_LEVELS];
      int j;
      if (node == '0 || int'(node) >= LCABL_MAX_NODES || int'(parent) >= LCABL_MAX_NODES)
         return;
      up[0] = parent;
      lo[0] = w;
      // rows are built from the old tables, so a self parent sees its old row
      for (j = 1; j < LCABL_LOG_LEVELS; j++) begin
         up[j] = lift_up[up[j-1]][j-1];
         lo[j] = lower_of(lo[j-1], lift_min[up[j-1]][j-1]);
      end
      node_depth[node] = node_depth[parent] + 1'b1;
      for (j = 0; j < LCABL_LOG_LEVELS; j++) begin
         lift_up[node][j]  = up[j];
         lift_min[node][j] = lo[j];
      end
   endtask

   function automatic rsp_type predict_path(
      input logic [NODE_W-1:0] qa,
      input logic [NODE_W-1:0] qb
   );
      rsp_type                    r;
      logic [NODE_W-1:0]          a, b, t, ua, ub;
      logic signed [WEIGHT_W-1:0] best;
      int i;
      r.ancestor = '0;
      r.path_min = INF;
      best = INF;
      a = qa;
      b = qb;
      if (a == '0 || b == '0 || int'(a) >= LCABL_MAX_NODES || int'(b) >= LCABL_MAX_NODES)
         return r;
      if (node_depth[a] > node_depth[b]) begin
         t = a;
         a = b;
         b = t;
      end
      // lift the deeper node to the depth of the shallower one
      for (i = LCABL_LOG_LEVELS - 1; i >= 0; i--) begin
         ua = lift_up[b][i];
         if (node_depth[ua] >= node_depth[a]) begin
            best = lower_of(best, lift_min[b][i]);
            b = ua;
         end
      end
      if (a == b) begin
         r.ancestor = a;
         r.path_min = best;
         return r;
      end
      for (i = LCABL_LOG_LEVELS - 1; i >= 0; i--) begin
         ua = lift_up[a][i];
         ub = lift_up[b][i];
         if (ua != ub) begin
            best = lower_of(best, lower_of(lift_min[a][i], lift_min[b][i]));
            a = ua;
            b = ub;
         end
      end
      best = lower_of(best, lower_of(lift_min[a][0], lift_min[b][0]));
      r.ancestor = lift_up[a][0];
      r.path_min = (r.ancestor == '0) ? INF : best;
      return r;
   endfunction

   initial begin
      mismatches = 0;
      waiting = 0;
      for (int n = 0; n < LCABL_MAX_NODES; n++) begin
         node_depth[n] = '0;
         for (int j = 0; j < LCABL_LOG_LEVELS; j++) begin
            lift_up[n][j]  = '0;
            lift_min[n][j] = '0;
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (expected_paths.size() == 0) begin
            $error("unexpected result word: ancestor %0d path_min %0d",
                   rsp_word.ancestor, rsp_word.path_min);
            mismatches++;
         end else begin
            want = expected_paths.pop_front();
            if (rsp_word.ancestor !== want.ancestor) begin
               $error("ancestor mismatch: expected %0d, actual %0d",
                      want.ancestor, rsp_word.ancestor);
               mismatches++;
            end
            if (rsp_word.path_min !== want.path_min) begin
               $error("path_min mismatch: expected %0d, actual %0d",
                      want.path_min, rsp_word.path_min);
               mismatches++;
            end
         end
      end
      // a result and a new word can share one edge; the result is older
      if (!reset && start && !busy) begin
         if (req_word.mode == MODE_QUERY)
            expected_paths.push_back(predict_path(req_word.node_a, req_word.node_b));
         else
            store_node(req_word.node_a, req_word.node_b, req_word.weight);
      end
      waiting = expected_paths.size();
   end

endmodule

[tb/lca_binary_lifting_path_min_test.sv]
// testbench top: stimulus for the binary-lifting lca engine and the verdict
`timescale 1ns / 1ps

module lca_binary_lifting_path_min_test;
   import lcabl_pkg::*;
   import lcabl_test_pkg::*;

   localparam logic signed [WEIGHT_W-1:0] W_MIN = 32'sh8000_0000;
   localparam logic signed [WEIGHT_W-1:0] W_MAX = 32'sh7FFF_FFFF;
   // longest query, used as the drain time at the end
   localparam int QUERY_CYCLES = 5 * LCABL_LOG_LEVELS + 5;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_word;
   logic    rsp_strobe;
   rsp_type rsp_word;
   int      error_count;
   int      pending_count;

   // stimulus bookkeeping: valid loads and queries name only loaded nodes
   // or node 0, so no unwritten table entry is read
   bit node_loaded [LCABL_MAX_NODES];
   int loaded_list [$];
   int last_node;
   int sender_idle_pct;

   lca_binary_lifting_path_min uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   lca_path_checker path_check (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_word      (req_word),
      .rsp_strobe    (rsp_strobe),
      .rsp_word      (rsp_word),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // watchdog, far beyond the slowest correct run
   initial begin
      #20_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // mostly random weights, with the extremes showing up often
   function automatic logic signed [WEIGHT_W-1:0] pick_weight();
      case ($urandom_range(9))
         0: return W_MIN;
         1: return W_MAX;
         2: return '0;
         3: return -1;
         default: return $urandom;
      endcase
   endfunction

   function automatic int any_loaded_node();
      return loaded_list[$urandom_range(loaded_list.size() - 1)];
   endfunction

   // called at a falling edge, returns at a falling edge; start stays high
   // into the next call unless that call idles first
   task automatic send_word(input req_type w);
      while ($urandom_range(99) < sender_idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      start = 1'b1;
      req_word = w;
      // busy read right after the edge holds its pre-edge value
      @(posedge clock);
      while (busy)
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_load(input int node, input int parent,
                            input logic signed [WEIGHT_W-1:0] w);
      req_type word;
      word.mode   = MODE_LOAD;
      word.node_a = NODE_W'(node);
      word.node_b = NODE_W'(parent);
      word.weight = w;
      send_word(word);
      if (node != 0) begin
         if (!node_loaded[node]) begin
            node_loaded[node] = 1'b1;
            loaded_list.push_back(node);
         end
         last_node = node;
      end
   endtask

   task automatic send_query(input int a, input int b);
      req_type word;
      word.mode   = MODE_QUERY;
      word.node_a = NODE_W'(a);
      word.node_b = NODE_W'(b);
      // weight is ignored on a query, but its bits still get toggled
      word.weight = $urandom;
      send_word(word);
   endtask

   // mostly well-formed forest growth and queries between loaded nodes,
   // with some ignored loads and node-0 queries as noise
   task automatic run_random(input int items);
      int sent, r, p, node, parent, a, b;
      sent = 0;
      while (sent < items) begin
         r = $urandom_range(99);
         if (r < 45) begin
            p = $urandom_range(99);
            if (loaded_list.size() == 0 ||
                (loaded_list.size() < LCABL_MAX_NODES - 1 && p < 75)) begin
               // fresh node
               do node = $urandom_range(LCABL_MAX_NODES - 1, 1);
               while (node_loaded[node]);
            end else begin
               // reload: descendants keep their stale rows
               node = any_loaded_node();
            end
            p = $urandom_range(99);
            if (loaded_list.size() == 0 || p < 8)
               parent = 0;
            else if (p < 55)
               parent = last_node;  // grows deep chains
            else if (p < 60 && node_loaded[node])
               parent = node;       // own parent
            else
               parent = any_loaded_node();
            send_load(node, parent, pick_weight());
            sent++;
         end else if (r < 90) begin
            if (loaded_list.size() == 0) begin
               send_query(0, 0);
            end else begin
               a = any_loaded_node();
               p = $urandom_range(99);
               if (p < 10)
                  b = a;
               else if (p < 25)
                  b = last_node;
               else
                  b = any_loaded_node();
               send_query(a, b);
            end
            sent++;
         end else if (r < 95) begin
            // load of node 0 is ignored and does not count
            send_load(0, $urandom_range(LCABL_MAX_NODES - 1), pick_weight());
         end else begin
            b = (loaded_list.size() == 0) ? 0 : any_loaded_node();
            if ($urandom_range(1))
               send_query(0, b);
            else
               send_query(b, 0);
            sent++;
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_word = '0;
      last_node = 0;
      sender_idle_pct = 0;
      repeat (10) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // directed part
      sender_idle_pct = 8;
      send_query(0, 0);                       // rejected node before any load
      send_load(1, 0, W_MIN);                 // root weight never shows
      send_load(2, 1, W_MAX);
      send_load(3, 1, -1);
      send_load(1023, 2, W_MIN);
      send_load(512, 1023, '0);
      send_load(4, 0, 5);                     // second tree
      send_load(0, 1023, -1);                 // ignored load
      send_query(1023, 3);                    // lca is the root
      send_query(512, 2);                     // one node above the other
      send_query(1, 1023);
      send_query(2, 2);                       // same node twice
      send_query(1023, 1023);
      send_query(512, 4);                     // different trees
      send_query(0, 512);
      send_query(512, 0);
      send_load(5, 1023, 32'sh5555_5555);
      send_query(5, 512);                     // siblings
      send_load(2, 2, 7);                     // own parent
      send_query(512, 3);
      send_load(2, 3, 100);                   // reload, children keep old rows
      send_query(1023, 3);
      send_query(5, 2);

      // random part, three idling regimes
      run_random(500);
      sender_idle_pct = 85;
      run_random(500);
      sender_idle_pct = 0;
      run_random(500);

      start = 1'b0;
      // checker updates its count at the rising edge, read it at the falling
      while (pending_count != 0)
         @(negedge clock);
      repeat (2 * QUERY_CYCLES) @(negedge clock);

      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
